// File: rtl/detector_subevent_hit_decoder_core_assert.svh
// Assertion macros used by the port checker of the hit decoder.
`ifndef DETECTOR_SUBEVENT_HIT_DECODER_CORE_ASSERT_SVH
`define DETECTOR_SUBEVENT_HIT_DECODER_CORE_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons must hold as well.
`define DSHD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold at the next clock.
`define DSHD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/dshd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dshd_pkg
// Types and constants shared by the subevent hit decoder modules.
// ----------------------------------------------------------------------------
package dshd_pkg;

   localparam int WORD_W       = 32;
   localparam int TARGET_W     = 31;
   localparam int MAX_RESULTS  = 5;
   localparam int RESULT_CNT_W = 3;

   localparam logic [TARGET_W-1:0] TARGET_RESET = 31'd1;

   // Byte codes, found in bits 6:4 of each data byte.
   localparam logic [2:0] CODE_END     = 3'd0;
   localparam logic [2:0] CODE_HIT     = 3'd4;
   localparam logic [2:0] CODE_STEP    = 3'd5;
   localparam logic [2:0] CODE_HIT_ROW = 3'd6;
   localparam logic [2:0] CODE_ROW     = 3'd7;

   typedef enum logic [2:0] {
      KIND_HIT     = 3'd0,
      KIND_DONE    = 3'd1,
      KIND_EARLY   = 3'd2,
      KIND_NO_END  = 3'd3,
      KIND_UNKNOWN = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  slice;
      logic [7:0]  column;
      logic [7:0]  row;
      logic [3:0]  channel;
      logic [15:0] hit_count;
   } result_type;

   // All results caused by one word, in order, and how many are valid.
   typedef struct packed {
      result_type [MAX_RESULTS-1:0] slot;
      logic [RESULT_CNT_W-1:0]      count;
   } batch_type;

   function automatic result_type make_result(input kind_type    kind,
                                              input logic [7:0]  slice,
                                              input logic [7:0]  column,
                                              input logic [7:0]  row,
                                              input logic [3:0]  channel,
                                              input logic [15:0] hit_count);
      result_type r;
      r.kind      = kind;
      r.slice     = slice;
      r.column    = column;
      r.row       = row;
      r.channel   = channel;
      r.hit_count = hit_count;
      return r;
   endfunction

endpackage

// File: rtl/dshd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dshd_decode
// Event walker and byte decoder: holds the parse state and produces the
// results of one word in a single pass.
// ----------------------------------------------------------------------------
module dshd_decode
   import dshd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [WORD_W-1:0]   word,
   input  logic                first_word,
   input  logic [TARGET_W-1:0] target_id,
   output batch_type           batch
);

   typedef enum logic [2:0] {
      PH_WAIT,
      PH_HEADER,
      PH_ID,
      PH_SIZE_SKIP,
      PH_SIZE_MATCH,
      PH_SKIP,
      PH_COUNT,
      PH_DATA
   } phase_type;

   phase_type         phase_ff, phase_in, next_rec;
   logic [1:0]        hdr_idx_ff, hdr_idx_in;
   logic [WORD_W-1:0] sub_left_ff, sub_left_in;
   logic [WORD_W-1:0] skip_left_ff, skip_left_in;
   logic [WORD_W-1:0] bytes_left_ff, bytes_left_in;
   logic [7:0]        slice_ff, slice_in;
   logic [7:0]        column_ff, column_in;
   logic [7:0]        row_ff, row_in;
   logic [15:0]       hits_ff, hits_in;

   // Walk temporaries.
   logic [2:0]              avail;
   logic [2:0]              used;
   logic                    live;
   logic [7:0]              byte_v;
   logic [2:0]              code_v;
   logic [3:0]              chan_v;
   logic [RESULT_CNT_W-1:0] n;
   logic                    word_empty;

   assign word_empty = word[WORD_W-1] || (word == '0);
   assign next_rec   = (sub_left_ff == '0) ? PH_WAIT : PH_ID;

   always_comb begin
      phase_in      = phase_ff;
      hdr_idx_in    = hdr_idx_ff;
      sub_left_in   = sub_left_ff;
      skip_left_in  = skip_left_ff;
      bytes_left_in = bytes_left_ff;
      slice_in      = slice_ff;
      column_in     = column_ff;
      row_in        = row_ff;
      hits_in       = hits_ff;
      batch         = '0;
      n             = '0;
      avail         = (bytes_left_ff > 32'd3) ? 3'd4 : bytes_left_ff[2:0];
      used          = '0;
      live          = 1'b1;
      byte_v        = '0;
      code_v        = '0;
      chan_v        = '0;

      if (first_word) begin
         // A flagged word always starts a new event, dropping any in progress.
         phase_in   = PH_HEADER;
         hdr_idx_in = 2'd1;
      end else begin
         unique case (phase_ff)
            PH_WAIT: begin
            end
            PH_HEADER: begin
               if (hdr_idx_ff != 2'd3) begin
                  hdr_idx_in = hdr_idx_ff + 2'd1;
               end else begin
                  hdr_idx_in  = '0;
                  sub_left_in = word[WORD_W-1] ? '0 : word;
                  phase_in    = word_empty ? PH_WAIT : PH_ID;
               end
            end
            PH_ID: begin
               phase_in    = (word == {1'b0, target_id}) ? PH_SIZE_MATCH : PH_SIZE_SKIP;
               sub_left_in = sub_left_ff - 32'd1;
            end
            PH_SIZE_SKIP: begin
               skip_left_in = word[WORD_W-1] ? '0 : word;
               phase_in     = word_empty ? next_rec : PH_SKIP;
            end
            PH_SKIP: begin
               skip_left_in = skip_left_ff - 32'd1;
               if (skip_left_ff == 32'd1) begin
                  phase_in = next_rec;
               end
            end
            PH_SIZE_MATCH: begin
               phase_in = PH_COUNT;
            end
            PH_COUNT: begin
               slice_in  = '0;
               column_in = '0;
               row_in    = '0;
               hits_in   = '0;
               if (word_empty) begin
                  bytes_left_in = '0;
                  batch.slot[0] = make_result(KIND_NO_END, 8'd0, 8'd0, 8'd0, 4'd0, 16'd0);
                  n             = 3'd1;
                  phase_in      = PH_WAIT;
               end else begin
                  bytes_left_in = word;
                  phase_in      = PH_DATA;
               end
            end
            PH_DATA: begin
               // Bytes go from bit 7:0 upward; the walk stops at an end code.
               for (int b = 0; b < 4; b++) begin
                  if (live && (3'(b) < avail)) begin
                     byte_v = word[8*b +: 8];
                     code_v = byte_v[6:4];
                     chan_v = byte_v[3:0];
                     used   = used + 3'd1;
                     unique case (code_v)
                        CODE_END: begin
                           batch.slot[n] = make_result(
                              (bytes_left_ff != 32'(b + 1)) ? KIND_EARLY : KIND_DONE,
                              slice_in, column_in, row_in, 4'd0, hits_in);
                           n             = n + 3'd1;
                           live          = 1'b0;
                           bytes_left_in = '0;
                           phase_in      = PH_WAIT;
                        end
                        CODE_HIT: begin
                           batch.slot[n] = make_result(KIND_HIT, slice_in, column_in,
                                                       row_in, chan_v, hits_in);
                           n             = n + 3'd1;
                           if (hits_in != 16'hffff) begin
                              hits_in = hits_in + 16'd1;
                           end
                        end
                        CODE_STEP: begin
                           row_in = '0;
                           if (chan_v != 4'd0) begin
                              column_in = '0;
                              slice_in  = slice_in + 8'd1;
                           end else begin
                              column_in = column_in + 8'd1;
                           end
                        end
                        CODE_HIT_ROW: begin
                           batch.slot[n] = make_result(KIND_HIT, slice_in, column_in,
                                                       row_in, chan_v, hits_in);
                           n             = n + 3'd1;
                           row_in        = row_in + 8'd1;
                        end
                        CODE_ROW: begin
                           row_in = row_in + 8'd1;
                        end
                        default: begin
                           batch.slot[n] = make_result(KIND_UNKNOWN, slice_in, column_in,
                                                       row_in, chan_v, hits_in);
                           n             = n + 3'd1;
                        end
                     endcase
                  end
               end
               if (live) begin
                  bytes_left_in = bytes_left_ff - {29'd0, used};
                  if (bytes_left_ff == {29'd0, used}) begin
                     batch.slot[n] = make_result(KIND_NO_END, slice_in, column_in,
                                                 row_in, 4'd0, hits_in);
                     n             = n + 3'd1;
                     phase_in      = PH_WAIT;
                  end
               end
            end
         endcase
      end
      batch.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_WAIT;
         hdr_idx_ff    <= '0;
         sub_left_ff   <= '0;
         skip_left_ff  <= '0;
         bytes_left_ff <= '0;
         slice_ff      <= '0;
         column_ff     <= '0;
         row_ff        <= '0;
         hits_ff       <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         hdr_idx_ff    <= hdr_idx_in;
         sub_left_ff   <= sub_left_in;
         skip_left_ff  <= skip_left_in;
         bytes_left_ff <= bytes_left_in;
         slice_ff      <= slice_in;
         column_ff     <= column_in;
         row_ff        <= row_in;
         hits_ff       <= hits_in;
      end
   end

endmodule

// File: rtl/detector_subevent_hit_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detector_subevent_hit_decoder_core
// Walks the words of an event, finds the subevent with the programmed id and
// turns its packed byte codes into hit and status results.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Beat
//   req_      in         req_valid/req_ready    one 32-bit event word + first flag
//   rsp_      out        rsp_valid/rsp_ready    one hit or status result
//   csr_      in         csr_wr_en              target subevent id, no wait
//
// A word that causes k results (at most 5) holds the result stage until all
// k are taken, so words flow at one per cycle until they start producing
// results or rsp_ready stalls; the single result port (one beat per cycle)
// then sets the rate. Words pass the input register, then the result queue.
// The input register takes the next word while results of the previous one
// are still draining, and reloads in the cycle the last of them is taken.
// Reset clears the parse state, the queue and the target id (to 1).
//
module detector_subevent_hit_decoder_core
   import dshd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // Input words.
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [WORD_W-1:0]   req_word,
   input  logic                req_first_word,
   // Results.
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_kind,
   output logic [7:0]          rsp_slice,
   output logic [7:0]          rsp_column,
   output logic [7:0]          rsp_row,
   output logic [3:0]          rsp_channel,
   output logic [15:0]         rsp_hit_count,
   output logic                rsp_last,
   // Configuration.
   input  logic                csr_wr_en,
   input  logic [TARGET_W-1:0] csr_wr_data
);

   // Target subevent id register.
   logic [TARGET_W-1:0] target_ff;

   // Input register: one word waiting to be decoded.
   logic                in_valid_ff;
   logic [WORD_W-1:0]   in_word_ff;
   logic                in_first_ff;

   // Result queue: slot 0 is presented on the port; the rest shift down on
   // every taken beat that loads no new batch. It only ever holds the results of one word.
   result_type [MAX_RESULTS-1:0] slot_ff;
   logic [RESULT_CNT_W-1:0]      count_ff;

   batch_type batch;
   logic      pop;
   logic      queue_free;
   logic      advance;

   assign pop        = rsp_valid && rsp_ready;
   // The queue can take a new batch when it is empty or its last beat leaves now.
   assign queue_free = (count_ff == '0) || ((count_ff == 3'd1) && rsp_ready);
   assign advance    = in_valid_ff && queue_free;
   assign req_ready  = !in_valid_ff || advance;

   dshd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .word       (in_word_ff),
      .first_word (in_first_ff),
      .target_id  (target_ff),
      .batch      (batch)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RESET;
      end else if (csr_wr_en) begin
         target_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff  <= req_word;
         in_first_ff <= req_first_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (advance) begin
         count_ff <= batch.count;
      end else if (pop) begin
         count_ff <= count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         slot_ff <= batch.slot;
      end else if (pop) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            slot_ff[i] <= slot_ff[i+1];
         end
      end
   end

   assign rsp_valid     = (count_ff != '0);
   assign rsp_last      = (count_ff == 3'd1);
   assign rsp_kind      = slot_ff[0].kind;
   assign rsp_slice     = slot_ff[0].slice;
   assign rsp_column    = slot_ff[0].column;
   assign rsp_row       = slot_ff[0].row;
   assign rsp_channel   = slot_ff[0].channel;
   assign rsp_hit_count = slot_ff[0].hit_count;

endmodule

// File: rtl/dshd_port_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dshd_port_checker
// Port-level checks on the result channel of the subevent hit decoder.
// ----------------------------------------------------------------------------
`include "detector_subevent_hit_decoder_core_assert.svh"

module dshd_port_checker
   import dshd_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [2:0]          rsp_kind,
   input logic [7:0]          rsp_slice,
   input logic [7:0]          rsp_column,
   input logic [7:0]          rsp_row,
   input logic [3:0]          rsp_channel,
   input logic [15:0]         rsp_hit_count,
   input logic                rsp_last
);

   // A stalled result beat stays on the port unchanged.
   `DSHD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_slice) && $stable(rsp_column) && $stable(rsp_row) && $stable(rsp_channel) && $stable(rsp_hit_count) && $stable(rsp_last), "result beat changed while stalled")

   // A subevent's closing status is always the final beat of its word, with no channel.
   `DSHD_ASSERT_NOW(a_status_last, clock, reset, rsp_valid && (rsp_kind == KIND_DONE || rsp_kind == KIND_EARLY || rsp_kind == KIND_NO_END), rsp_last && (rsp_channel == 4'd0), "closing status not last or has a channel")

   // Results of one word come out back to back.
   `DSHD_ASSERT_NEXT(a_burst, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_valid, "gap inside the results of one word")

   // Reset empties the result queue.
   `DSHD_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "result valid right after reset")

endmodule

bind detector_subevent_hit_decoder_core dshd_port_checker u_port_checker (.*);
